### design/mash_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mash_pkg
// Shared types and constants for the multi-algorithm string hash unit.
// ----------------------------------------------------------------------------
package mash_pkg;

    localparam int HASH_W = 32;
    localparam int SEL_W  = 4;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [HASH_W-1:0] RS_MULT_INIT = 32'd63689;
    localparam logic [HASH_W-1:0] RS_MULT_STEP = 32'd378551;
    localparam logic [HASH_W-1:0] JS_INIT      = 32'd1315423911;
    localparam logic [HASH_W-1:0] BKDR_SEED    = 32'd131;
    localparam logic [HASH_W-1:0] DJB_INIT     = 32'd5381;
    localparam logic [HASH_W-1:0] AP_INIT      = 32'hAAAA_AAAA;

    // Register index carried by paddr[2].
    localparam logic REG_ALGO_SEL = 1'b0;

    typedef enum logic [SEL_W-1:0] {
        ALG_RS   = 4'd0,
        ALG_JS   = 4'd1,
        ALG_PJW  = 4'd2,
        ALG_ELF  = 4'd3,
        ALG_BKDR = 4'd4,
        ALG_SDBM = 4'd5,
        ALG_DJB  = 4'd6,
        ALG_DEK  = 4'd7,
        ALG_AP   = 4'd8
    } t_algo;

    typedef struct packed {
        logic [SEL_W-1:0] sel;
        logic             first;
        logic             odd;
    } t_fold_ctl;

endpackage

### design/mash_fold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mash_fold
// Folds one sign-extended byte into the running hash for the selected
// algorithm, applying the start value first when the byte opens a string.
// ----------------------------------------------------------------------------
module mash_fold (
    input  mash_pkg::t_fold_ctl              i_ctl,
    input  logic [mash_pkg::BYTE_W-1:0]      i_byte,
    input  logic [mash_pkg::LEN_W-1:0]       i_len,
    input  logic [mash_pkg::HASH_W-1:0]      i_hash,
    input  logic [mash_pkg::HASH_W-1:0]      i_mult,
    output logic [mash_pkg::HASH_W-1:0]      o_hash,
    output logic [mash_pkg::HASH_W-1:0]      o_mult,
    output logic                             o_odd
);
    import mash_pkg::*;

    logic [HASH_W-1:0] c;
    logic [HASH_W-1:0] h0;
    logic [HASH_W-1:0] m0;
    logic [HASH_W-1:0] start;
    logic [HASH_W-1:0] mul_a;
    logic [HASH_W-1:0] mul_b;
    logic [HASH_W-1:0] prod;
    logic [HASH_W-1:0] t4;
    logic              odd0;

    assign c = {{(HASH_W-BYTE_W){i_byte[BYTE_W-1]}}, i_byte};

    always_comb begin
        unique case (i_ctl.sel)
            ALG_JS:  start = JS_INIT;
            ALG_DJB: start = DJB_INIT;
            ALG_DEK: start = {{(HASH_W-LEN_W){1'b0}}, i_len};
            ALG_AP:  start = AP_INIT;
            default: start = '0;
        endcase
    end

    assign h0   = i_ctl.first ? start : i_hash;
    assign m0   = i_ctl.first ? RS_MULT_INIT : i_mult;
    assign odd0 = i_ctl.first ? 1'b0 : i_ctl.odd;

    // One shared multiplier serves RS, BKDR and the even AP step.
    always_comb begin
        unique case (i_ctl.sel)
            ALG_RS: begin
                mul_a = h0;
                mul_b = m0;
            end
            ALG_AP: begin
                mul_a = h0 >> 3;
                mul_b = c;
            end
            default: begin
                mul_a = h0;
                mul_b = BKDR_SEED;
            end
        endcase
    end

    assign prod = mul_a * mul_b;
    assign t4   = (h0 << 4) + c;

    always_comb begin
        o_mult = m0;
        unique case (i_ctl.sel)
            ALG_RS: begin
                o_hash = prod + c;
                o_mult = m0 * RS_MULT_STEP;
            end
            ALG_JS:   o_hash = h0 ^ ((h0 << 5) + c + (h0 >> 2));
            // In 32-bit form PJW and ELF reduce to the same fold.
            ALG_PJW, ALG_ELF: begin
                o_hash = {4'b0000, t4[27:8], t4[7:4] ^ t4[31:28], t4[3:0]};
            end
            ALG_BKDR: o_hash = prod + c;
            ALG_SDBM: o_hash = c + (h0 << 6) + (h0 << 16) - h0;
            ALG_DJB:  o_hash = (h0 << 5) + h0 + c;
            ALG_DEK:  o_hash = (h0 << 5) ^ (h0 >> 27) ^ c;
            ALG_AP: begin
                if (!odd0) begin
                    o_hash = h0 ^ ((h0 << 7) ^ prod);
                end else begin
                    o_hash = h0 ^ ~((h0 << 11) + (c ^ (h0 >> 5)));
                end
            end
            default:  o_hash = h0;
        endcase
    end

    assign o_odd = ~odd0;

endmodule

### design/multi_algorithm_string_hash_unit.sv
`timescale 1ns / 1ps
// A word accepted into the input register is folded into the hash state when it advances,
// and a last word's hash is registered into the result register when the output side is free.
// Throughput: one word per cycle while the output side is not stalled; the fold closes the loop
// through the state registers with the shared 32x32 multiplier and the RS multiplier step beside it.
// A result still waiting on the output side stalls the input register, last or not.
// Reset is synchronous and active low; it clears the handshake state, selects RS.
// ----------------------------------------------------------------------------
// multi_algorithm_string_hash_unit
// Folds a byte stream into one of nine 32-bit string hashes and emits the
// hash on the word marked last.
// ----------------------------------------------------------------------------
module multi_algorithm_string_hash_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [mash_pkg::BYTE_W-1:0]      i_data_byte,
    input  logic                             i_first_flag,
    input  logic                             i_last_flag,
    input  logic [mash_pkg::LEN_W-1:0]       i_string_length,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [mash_pkg::HASH_W-1:0]      o_hash_value,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mash_pkg::ADDR_W-1:0]      paddr,
    input  logic [mash_pkg::DATA_W-1:0]      pwdata,
    output logic [mash_pkg::DATA_W-1:0]      prdata,
    output logic                             pready
);
    import mash_pkg::*;

    logic [SEL_W-1:0]  r_sel;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_first;
    logic              r_last;
    logic [LEN_W-1:0]  r_len;
    logic [HASH_W-1:0] r_hash;
    logic [HASH_W-1:0] r_mult;
    logic              r_odd;
    logic              r_out_valid;
    logic [HASH_W-1:0] r_out_hash;

    logic [HASH_W-1:0] n_hash;
    logic [HASH_W-1:0] n_mult;
    logic              n_odd;
    logic              advance;
    logic              accept;
    logic              cfg_wr;
    t_fold_ctl         fold_ctl;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == REG_ALGO_SEL);
    assign prdata  = (paddr[2] == REG_ALGO_SEL) ? {{(DATA_W-SEL_W){1'b0}}, r_sel} : '0;

    // The fold only stalls when the result register is still full.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign accept     = i_in_valid && o_in_ready;

    assign fold_ctl.sel   = r_sel;
    assign fold_ctl.first = r_first;
    assign fold_ctl.odd   = r_odd;

    mash_fold u_fold (
        .i_ctl  (fold_ctl),
        .i_byte (r_byte),
        .i_len  (r_len),
        .i_hash (r_hash),
        .i_mult (r_mult),
        .o_hash (n_hash),
        .o_mult (n_mult),
        .o_odd  (n_odd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel       <= ALG_RS;
            r_in_valid  <= 1'b0;
            r_hash      <= '0;
            r_mult      <= RS_MULT_INIT;
            r_odd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_sel <= pwdata[SEL_W-1:0];
            end
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_hash <= n_hash;
                r_mult <= n_mult;
                r_odd  <= n_odd;
            end
            if (advance && r_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte  <= i_data_byte;
            r_first <= i_first_flag;
            r_last  <= i_last_flag;
            r_len   <= i_string_length;
        end
        if (advance && r_last) begin
            r_out_hash <= n_hash;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_out_hash;

endmodule

### design/mash_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mash_checker
// Port-level checks for the string hash unit, bound to the top level.
// ----------------------------------------------------------------------------
module mash_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             o_in_ready,
    input  logic                             o_out_valid,
    input  logic                             i_out_ready,
    input  logic [mash_pkg::HASH_W-1:0]      o_hash_value,
    input  logic                             pready
);
    import mash_pkg::*;

    // A result that is not taken stays on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_hash_value)))
        else $error("result word dropped or changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // With the result register empty, nothing can block the input side.
    a_ready_when_empty: assert property (@(posedge i_clk)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // A new result only appears when the fold stage has moved, so input ready must have been high.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(o_in_ready) && $past(pready)))
        else $error("result appeared without a fold");

endmodule

bind multi_algorithm_string_hash_unit mash_checker u_mash_checker (.*);
